// ----- hw/rtl/priority_queues_with_lru_eviction_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the priority queue block.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_QUEUES_WITH_LRU_EVICTION_TOP_MACROS_SVH
`define PRIORITY_QUEUES_WITH_LRU_EVICTION_TOP_MACROS_SVH

// Same-cycle implication.
`define PQLRU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PQLRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pqlru_pkg.sv -----
// ----------------------------------------------------------------------------
// pqlru_pkg
// Types, codes and constants of the priority queue block with LRU eviction.
// ----------------------------------------------------------------------------
package pqlru_pkg;

    localparam int DEF_RECORD_SLOTS = 64;
    localparam int REC_W  = 6;
    localparam int OP_W   = 3;
    localparam int PRI_W  = 2;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;
    localparam int TAG_W  = 3;
    localparam int LIST_W = 2;
    localparam int CFG_ADDR_W = 3;

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_EVICT = 3'd1;
    localparam logic [OP_W-1:0] OP_TOUCH     = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
    localparam logic [OP_W-1:0] OP_REPRIO    = 3'd4;
    localparam logic [OP_W-1:0] OP_DEQUEUE   = 3'd5;
    localparam logic [OP_W-1:0] OP_FLUSH     = 3'd6;

    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EVICT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd2;

    localparam logic [LIST_W-1:0] LIST_HIGH  = 2'd0;
    localparam logic [LIST_W-1:0] LIST_MED   = 2'd1;
    localparam logic [LIST_W-1:0] LIST_LOW   = 2'd2;
    localparam logic [LIST_W-1:0] LIST_EVICT = 2'd3;

    localparam logic [TAG_W-1:0] TAG_NONE  = 3'd0;
    localparam logic [TAG_W-1:0] TAG_EVICT = 3'd4;

    localparam logic [CNT_W-1:0]      MAX_RESET     = 7'd64;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_CACHE = 3'd0;

    typedef struct packed {
        logic              capture;
        logic              rd_slot;
        logic              rd_head;
        logic              unlink;
        logic              push;
        logic [LIST_W-1:0] lsel;
        logic              pend_inc;
        logic              pend_dec;
        logic              ev_inc;
        logic              ev_dec;
        logic              ev_clr;
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] status;
        logic              emit_id;
        logic              last;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              slot_ok;
        logic [LIST_W-1:0] pri;
        logic              listed;
        logic              pending;
        logic              evict;
        logic              dq_any;
        logic [LIST_W-1:0] dq_list;
        logic              ev_nonempty;
        logic              ev_room;
        logic              out_free;
    } t_dp_stat;

endpackage

// ----- hw/rtl/pqlru_if.sv -----
// ----------------------------------------------------------------------------
// pqlru_if
// Request and response channel interfaces of the priority queue block.
// ----------------------------------------------------------------------------
interface pqlru_req_if import pqlru_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [REC_W-1:0]  record;
    logic [PRI_W-1:0]  priority_req;
    logic              high_only;
    modport source (output valid, operation, record, priority_req, high_only, input ready);
    modport sink   (input valid, operation, record, priority_req, high_only, output ready);
endinterface

interface pqlru_rsp_if import pqlru_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [STAT_W-1:0] status;
    logic [REC_W-1:0]  record_id;
    logic              last;
    logic [CNT_W-1:0]  pending_count;
    logic [CNT_W-1:0]  eviction_count;
    modport source (output valid, result_kind, status, record_id, last, pending_count,
                    eviction_count, input ready);
    modport sink   (input valid, result_kind, status, record_id, last, pending_count,
                    eviction_count, output ready);
endinterface

// ----- hw/rtl/pqlru_dp.sv -----
// ----------------------------------------------------------------------------
// pqlru_dp
// Link memories, list heads and tails, counters and the result register.
// ----------------------------------------------------------------------------
module pqlru_dp import pqlru_pkg::*; #(
    parameter int RECORD_SLOTS = DEF_RECORD_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [REC_W-1:0]  i_record,
    input  logic [PRI_W-1:0]  i_priority_req,
    input  logic              i_high_only,
    input  logic [CNT_W-1:0]  i_max,
    pqlru_rsp_if.source       o_rsp
);

    localparam int SLOTS = (RECORD_SLOTS < 64) ? RECORD_SLOTS : 64;
    localparam int SW    = $clog2(SLOTS);

    logic [OP_W-1:0]   r_op;
    logic [SW-1:0]     r_slot;
    logic              r_slot_ok;
    logic [LIST_W-1:0] r_pri;
    logic              r_hi_only;

    logic [TAG_W-1:0]  mem_tag  [SLOTS];
    logic [SW-1:0]     mem_next [SLOTS];
    logic [SW-1:0]     mem_prev [SLOTS];
    logic [SLOTS-1:0]  r_tvalid;

    logic [SW-1:0]     r_head [4];
    logic [SW-1:0]     r_tail [4];
    logic [3:0]        r_nonempty;

    logic [SW-1:0]     r_cur;
    logic [TAG_W-1:0]  r_rtag_m;
    logic              r_rvalid;
    logic [SW-1:0]     r_rnext;
    logic [SW-1:0]     r_rprev;

    logic [CNT_W-1:0]  r_pend;
    logic [CNT_W-1:0]  r_ev;

    logic              r_ovalid;
    logic [KIND_W-1:0] r_okind;
    logic [STAT_W-1:0] r_ostat;
    logic [REC_W-1:0]  r_oid;
    logic              r_olast;
    logic [CNT_W-1:0]  r_opend;
    logic [CNT_W-1:0]  r_oev;

    logic [TAG_W-1:0]  rtag;
    logic [TAG_W-1:0]  rtag_m1;
    logic [LIST_W-1:0] lidx;
    logic [SW-1:0]     cur_head;
    logic [SW-1:0]     cur_tail;
    logic              is_h;
    logic              is_t;
    logic              rd_en;
    logic [SW-1:0]     rd_addr;
    logic              wn_en;
    logic [SW-1:0]     wn_addr;
    logic [SW-1:0]     wn_data;
    logic              wp_en;
    logic [SW-1:0]     wp_addr;
    logic [SW-1:0]     wp_data;
    logic              out_free;

    assign rtag     = r_rvalid ? r_rtag_m : TAG_NONE;
    assign rtag_m1  = rtag - 3'd1;
    assign lidx     = i_cmd.unlink ? rtag_m1[LIST_W-1:0] : i_cmd.lsel;
    assign cur_head = r_head[lidx];
    assign cur_tail = r_tail[lidx];
    assign is_h     = (cur_head == r_cur);
    assign is_t     = (cur_tail == r_cur);
    assign rd_en    = i_cmd.rd_slot | i_cmd.rd_head;
    assign rd_addr  = i_cmd.rd_head ? cur_head : r_slot;
    assign out_free = !r_ovalid || o_rsp.ready;

    always_comb begin
        wn_en   = 1'b0;
        wn_addr = r_rprev;
        wn_data = r_rnext;
        wp_en   = 1'b0;
        wp_addr = r_rnext;
        wp_data = r_rprev;
        if (i_cmd.unlink) begin
            if (!is_h && !is_t) begin
                wn_en = 1'b1;
                wp_en = 1'b1;
            end
        end else if (i_cmd.push && r_nonempty[lidx]) begin
            wn_en   = 1'b1;
            wn_addr = cur_tail;
            wn_data = r_cur;
            wp_en   = 1'b1;
            wp_addr = r_cur;
            wp_data = cur_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_cur    <= rd_addr;
            r_rtag_m <= mem_tag[rd_addr];
            r_rvalid <= r_tvalid[rd_addr];
            r_rnext  <= mem_next[rd_addr];
            r_rprev  <= mem_prev[rd_addr];
        end
        if (wn_en) begin
            mem_next[wn_addr] <= wn_data;
        end
        if (wp_en) begin
            mem_prev[wp_addr] <= wp_data;
        end
        if (i_cmd.push) begin
            mem_tag[r_cur] <= TAG_W'(lidx) + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_operation;
            r_slot    <= i_record[SW-1:0];
            r_slot_ok <= (32'(i_record) < 32'(RECORD_SLOTS));
            r_pri     <= (i_priority_req == 2'd3) ? LIST_LOW : i_priority_req;
            r_hi_only <= i_high_only;
        end
        if (i_cmd.unlink) begin
            if (is_h && !is_t) begin
                r_head[lidx] <= r_rnext;
            end else if (!is_h && is_t) begin
                r_tail[lidx] <= r_rprev;
            end
        end else if (i_cmd.push) begin
            r_tail[lidx] <= r_cur;
            if (!r_nonempty[lidx]) begin
                r_head[lidx] <= r_cur;
            end
        end
        if (i_cmd.emit) begin
            r_okind <= i_cmd.kind;
            r_ostat <= i_cmd.status;
            r_oid   <= i_cmd.emit_id ? REC_W'(r_cur) : '0;
            r_olast <= i_cmd.last;
            r_opend <= r_pend;
            r_oev   <= r_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid   <= '0;
            r_nonempty <= '0;
            r_pend     <= '0;
            r_ev       <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cmd.unlink) begin
                r_tvalid[r_cur] <= 1'b0;
                if (is_h && is_t) begin
                    r_nonempty[lidx] <= 1'b0;
                end
            end else if (i_cmd.push) begin
                r_tvalid[r_cur]  <= 1'b1;
                r_nonempty[lidx] <= 1'b1;
            end
            if (i_cmd.pend_inc) begin
                r_pend <= r_pend + 7'd1;
            end else if (i_cmd.pend_dec && (r_pend != '0)) begin
                r_pend <= r_pend - 7'd1;
            end
            if (i_cmd.ev_clr) begin
                r_ev <= '0;
            end else if (i_cmd.ev_inc) begin
                r_ev <= r_ev + 7'd1;
            end else if (i_cmd.ev_dec && (r_ev != '0)) begin
                r_ev <= r_ev - 7'd1;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.op          = r_op;
        o_stat.slot_ok     = r_slot_ok;
        o_stat.pri         = r_pri;
        o_stat.listed      = (rtag != TAG_NONE);
        o_stat.pending     = (rtag != TAG_NONE) && (rtag < TAG_EVICT);
        o_stat.evict       = (rtag == TAG_EVICT);
        o_stat.ev_nonempty = r_nonempty[LIST_EVICT];
        o_stat.ev_room     = (r_ev < i_max);
        o_stat.out_free    = out_free;
        o_stat.dq_any      = 1'b1;
        priority if (r_nonempty[LIST_HIGH]) begin
            o_stat.dq_list = LIST_HIGH;
        end else if (!r_hi_only && r_nonempty[LIST_MED]) begin
            o_stat.dq_list = LIST_MED;
        end else if (!r_hi_only && r_nonempty[LIST_LOW]) begin
            o_stat.dq_list = LIST_LOW;
        end else begin
            o_stat.dq_list = LIST_HIGH;
            o_stat.dq_any  = 1'b0;
        end
    end

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.result_kind    = r_okind;
    assign o_rsp.status         = r_ostat;
    assign o_rsp.record_id      = r_oid;
    assign o_rsp.last           = r_olast;
    assign o_rsp.pending_count  = r_opend;
    assign o_rsp.eviction_count = r_oev;

endmodule

// ----- hw/rtl/pqlru_ctrl.sv -----
// ----------------------------------------------------------------------------
// pqlru_ctrl
// Sequencer that steps each operation through reads, unlinks and pushes.
// ----------------------------------------------------------------------------
module pqlru_ctrl import pqlru_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DISP  = 9'b000000010,
        S_CHK   = 9'b000000100,
        S_PUSH  = 9'b000001000,
        S_ROOM  = 9'b000010000,
        S_HUNL  = 9'b000100000,
        S_FUNL  = 9'b001000000,
        S_FEMIT = 9'b010000000,
        S_EMIT  = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [STAT_W-1:0] r_stat, n_stat;
    logic              r_id, n_id;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_stat  = r_stat;
        n_id    = r_id;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_valid;
                if (i_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_kind = KIND_ACK;
                n_stat = STAT_OK;
                n_id   = 1'b0;
                n_state = S_EMIT;
                priority if (i_stat.op == OP_DEQUEUE) begin
                    if (i_stat.dq_any) begin
                        o_cmd.rd_head = 1'b1;
                        o_cmd.lsel    = i_stat.dq_list;
                        n_state       = S_HUNL;
                    end else begin
                        n_kind = KIND_DEQ;
                        n_stat = STAT_EMPTY;
                    end
                end else if (i_stat.op == OP_FLUSH) begin
                    o_cmd.ev_clr = 1'b1;
                    if (i_stat.ev_nonempty) begin
                        o_cmd.rd_head = 1'b1;
                        o_cmd.lsel    = LIST_EVICT;
                        n_state       = S_FUNL;
                    end
                end else if (i_stat.slot_ok && (i_stat.op <= OP_REPRIO)) begin
                    o_cmd.rd_slot = 1'b1;
                    n_state       = S_CHK;
                end
            end
            S_CHK: begin
                n_state = S_EMIT;
                priority if (i_stat.op == OP_INSERT) begin
                    if (i_stat.listed) begin
                        n_stat = STAT_REFUSED;
                    end else begin
                        o_cmd.push     = 1'b1;
                        o_cmd.lsel     = i_stat.pri;
                        o_cmd.pend_inc = 1'b1;
                    end
                end else if (i_stat.op == OP_ADD_EVICT) begin
                    if (i_stat.listed) begin
                        o_cmd.unlink   = 1'b1;
                        o_cmd.ev_dec   = i_stat.evict;
                        o_cmd.pend_dec = i_stat.pending;
                        n_state        = S_PUSH;
                    end else begin
                        o_cmd.push = 1'b1;
                        o_cmd.lsel = LIST_EVICT;
                        n_state    = S_ROOM;
                    end
                end else if (i_stat.op == OP_TOUCH) begin
                    if (i_stat.evict) begin
                        o_cmd.unlink = 1'b1;
                        n_state      = S_PUSH;
                    end
                end else if (i_stat.op == OP_REMOVE) begin
                    o_cmd.unlink   = i_stat.pending || i_stat.evict;
                    o_cmd.pend_dec = i_stat.pending;
                    o_cmd.ev_dec   = i_stat.evict;
                end else begin
                    if (i_stat.pending) begin
                        o_cmd.unlink = 1'b1;
                        n_state      = S_PUSH;
                    end else begin
                        n_stat = STAT_REFUSED;
                    end
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                o_cmd.lsel = (i_stat.op == OP_REPRIO) ? i_stat.pri : LIST_EVICT;
                n_state    = (i_stat.op == OP_ADD_EVICT) ? S_ROOM : S_EMIT;
            end
            S_ROOM: begin
                if (i_stat.ev_room) begin
                    o_cmd.ev_inc = 1'b1;
                    n_state      = S_EMIT;
                end else begin
                    o_cmd.rd_head = 1'b1;
                    o_cmd.lsel    = LIST_EVICT;
                    n_state       = S_HUNL;
                end
            end
            S_HUNL: begin
                o_cmd.unlink   = 1'b1;
                o_cmd.pend_dec = (i_stat.op == OP_DEQUEUE);
                n_kind         = (i_stat.op == OP_DEQUEUE) ? KIND_DEQ : KIND_EVICT;
                n_id           = 1'b1;
                n_state        = S_EMIT;
            end
            S_FUNL: begin
                o_cmd.unlink = 1'b1;
                n_state      = S_FEMIT;
            end
            S_FEMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.kind    = KIND_FLUSH;
                    o_cmd.status  = STAT_OK;
                    o_cmd.emit_id = 1'b1;
                    o_cmd.last    = !i_stat.ev_nonempty;
                    if (i_stat.ev_nonempty) begin
                        o_cmd.rd_head = 1'b1;
                        o_cmd.lsel    = LIST_EVICT;
                        n_state       = S_FUNL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.kind    = r_kind;
                    o_cmd.status  = r_stat;
                    o_cmd.emit_id = r_id;
                    o_cmd.last    = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_stat <= n_stat;
        r_id   <= n_id;
    end

endmodule

// ----- hw/rtl/priority_queues_with_lru_eviction_top.sv -----
// ----------------------------------------------------------------------------
// priority_queues_with_lru_eviction_top
// Three strict priority FIFOs and an LRU eviction list over linked slots.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Carries
//  i_req     in         valid/ready          operation, record, priority, high_only
//  o_rsp     out        valid/ready          kind, status, id, last, counts
//  APB       in         psel/penable/pready  max_cache_entries at byte address 0
//
//  A transaction steps through reads, unlinks and pushes; a flush walks the
//  eviction list entry by entry. The link memories have a single read port.
//  Reset is synchronous; no clearing pass is needed as tags have valid bits.
//  A result waits in the output register while the next transaction is taken.
// ----------------------------------------------------------------------------
module priority_queues_with_lru_eviction_top import pqlru_pkg::*; #(
    parameter int RECORD_SLOTS = DEF_RECORD_SLOTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pqlru_req_if.sink             i_req,
    pqlru_rsp_if.source           o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [CNT_W-1:0] r_max;
    logic             cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == REG_MAX_CACHE);
    assign prdata = (paddr == REG_MAX_CACHE) ? 32'(r_max) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_RESET;
        end else if (cfg_we) begin
            r_max <= pwdata[CNT_W-1:0];
        end
    end

    pqlru_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pqlru_dp #(
        .RECORD_SLOTS (RECORD_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_operation    (i_req.operation),
        .i_record       (i_req.record),
        .i_priority_req (i_req.priority_req),
        .i_high_only    (i_req.high_only),
        .i_max          (r_max),
        .o_rsp          (o_rsp)
    );

`include "priority_queues_with_lru_eviction_top_macros.svh"

    `PQLRU_ASSERT_NEXT(a_busy_after_take, i_req.valid && i_req.ready, !i_req.ready, "input taken twice")
    `PQLRU_ASSERT_NOW(a_only_flush_multi, o_rsp.valid && !o_rsp.last, o_rsp.result_kind == KIND_FLUSH, "non-final result outside flush")
    `PQLRU_ASSERT_NOW(a_pending_bound, o_rsp.valid, 32'(o_rsp.pending_count) <= 32'(RECORD_SLOTS), "pending count exceeds slots")

endmodule

// ----- sim/priority_queues_with_lru_eviction_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_queues_with_lru_eviction_checker
// Watches the request and response channels, keeps a software copy of the
// priority lists and the eviction list, and compares every response field by
// field with the oldest expected one.
// ----------------------------------------------------------------------------
module priority_queues_with_lru_eviction_checker import pqlru_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pqlru_req_if       req,
    pqlru_rsp_if       rsp,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_max,
    output int         o_errors,
    output int         o_outstanding,
    output int         o_kind_seen [4]
);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] status;
        logic [REC_W-1:0]  id;
        logic              last;
        logic [CNT_W-1:0]  pend;
        logic [CNT_W-1:0]  evc;
    } t_result;

    t_result    expected_results[$];
    logic [2:0] tag [64];
    logic [5:0] nxt [64];
    logic [5:0] prv [64];
    logic [5:0] head [4];
    logic [5:0] tail [4];
    logic       nonempty [4];
    int         pend_total;
    int         evict_total;
    int         max_entries;

    assign o_outstanding = expected_results.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    function automatic void unlink_slot(input int s);
        int l;
        int p;
        int n;
        if (tag[s] < 1 || tag[s] > 4) return;
        l = tag[s] - 1;
        p = prv[s];
        n = nxt[s];
        if (head[l] == s && tail[l] == s) nonempty[l] = 0;
        else if (head[l] == s) head[l] = 6'(n);
        else if (tail[l] == s) begin
            tail[l] = 6'(p);
            nxt[p] = 6'(p);
        end else begin
            nxt[p] = 6'(n);
            prv[n] = 6'(p);
        end
        tag[s] = TAG_NONE;
    endfunction

    function automatic void push_tail(input int l, input int s);
        if (nonempty[l]) begin
            nxt[tail[l]] = 6'(s);
            prv[s] = tail[l];
            tail[l] = 6'(s);
        end else begin
            head[l] = 6'(s);
            tail[l] = 6'(s);
            nonempty[l] = 1;
        end
        tag[s] = 3'(l + 1);
    endfunction

    function automatic void predict_results(input logic [2:0] op, input int s,
                                            input int pr_in, input logic hi);
        t_result r[$];
        t_result e;
        int      pr;
        int      l;
        int      h;
        int      t;
        logic    pending;
        logic    in_evict;
        logic [STAT_W-1:0] st;
        pr = (pr_in > 2) ? 2 : pr_in;
        e = '0;
        e.last = 1;
        if (op == OP_DEQUEUE) begin
            l = 4;
            if (nonempty[LIST_HIGH]) l = LIST_HIGH;
            else if (!hi && nonempty[LIST_MED]) l = LIST_MED;
            else if (!hi && nonempty[LIST_LOW]) l = LIST_LOW;
            e.kind = KIND_DEQ;
            if (l < 3) begin
                h = head[l];
                unlink_slot(h);
                if (pend_total > 0) pend_total--;
                e.id = 6'(h);
            end else begin
                e.status = STAT_EMPTY;
            end
            r.push_back(e);
        end else if (op == OP_FLUSH) begin
            while (nonempty[LIST_EVICT]) begin
                h = head[LIST_EVICT];
                unlink_slot(h);
                e.kind = KIND_FLUSH;
                e.id = 6'(h);
                e.last = 0;
                r.push_back(e);
            end
            evict_total = 0;
            if (r.size() == 0) begin
                e.last = 1;
                r.push_back(e);
            end else begin
                r[r.size()-1].last = 1;
            end
        end else if (op == 3'd7) begin
            r.push_back(e);
        end else begin
            t = tag[s];
            pending = t >= 1 && t <= 3;
            in_evict = t == TAG_EVICT;
            st = STAT_OK;
            case (op)
                OP_INSERT: begin
                    if (t != 0) st = STAT_REFUSED;
                    else begin
                        push_tail(pr, s);
                        pend_total++;
                    end
                end
                OP_ADD_EVICT: begin
                    if (in_evict) begin
                        unlink_slot(s);
                        if (evict_total > 0) evict_total--;
                    end else if (t != 0) begin
                        unlink_slot(s);
                        if (pending && pend_total > 0) pend_total--;
                    end
                    push_tail(LIST_EVICT, s);
                    if (evict_total < max_entries) evict_total++;
                    else begin
                        h = head[LIST_EVICT];
                        unlink_slot(h);
                        e.kind = KIND_EVICT;
                        e.id = 6'(h);
                    end
                end
                OP_TOUCH: begin
                    if (in_evict) begin
                        unlink_slot(s);
                        push_tail(LIST_EVICT, s);
                    end
                end
                OP_REMOVE: begin
                    if (pending) begin
                        unlink_slot(s);
                        if (pend_total > 0) pend_total--;
                    end else if (in_evict) begin
                        unlink_slot(s);
                        if (evict_total > 0) evict_total--;
                    end
                end
                default: begin
                    if (pending) begin
                        unlink_slot(s);
                        push_tail(pr, s);
                    end else st = STAT_REFUSED;
                end
            endcase
            e.status = st;
            r.push_back(e);
        end
        foreach (r[i]) begin
            r[i].pend = 7'(pend_total);
            r[i].evc = 7'(evict_total);
            expected_results.push_back(r[i]);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result w;
        if (!i_rst_n) begin
            for (int i = 0; i < 64; i++) tag[i] = TAG_NONE;
            for (int i = 0; i < 4; i++) nonempty[i] = 0;
            pend_total = 0;
            evict_total = 0;
            max_entries = MAX_RESET;
            o_errors = 0;
            for (int i = 0; i < 4; i++) o_kind_seen[i] = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) max_entries = i_cfg_max;
            if (rsp.valid && rsp.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: response transaction with nothing expected", $realtime);
                    o_errors++;
                end else begin
                    w = expected_results.pop_front();
                    o_kind_seen[rsp.result_kind]++;
                    if (rsp.result_kind !== w.kind)
                        report_mismatch("result_kind", rsp.result_kind, w.kind);
                    if (rsp.status !== w.status)
                        report_mismatch("status", rsp.status, w.status);
                    if (rsp.record_id !== w.id)
                        report_mismatch("record_id", rsp.record_id, w.id);
                    if (rsp.last !== w.last)
                        report_mismatch("last", rsp.last, w.last);
                    if (rsp.pending_count !== w.pend)
                        report_mismatch("pending_count", rsp.pending_count, w.pend);
                    if (rsp.eviction_count !== w.evc)
                        report_mismatch("eviction_count", rsp.eviction_count, w.evc);
                end
            end
            if (req.valid && req.ready)
                predict_results(req.operation, req.record, req.priority_req, req.high_only);
        end
    end

endmodule

// ----- sim/priority_queues_with_lru_eviction_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_queues_with_lru_eviction_top_tb
// Drives list operations into the priority queue block with random gaps and
// back-pressure, writes the eviction limit between phases, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module priority_queues_with_lru_eviction_top_tb import pqlru_pkg::*;;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          outstanding;
    int          kind_seen [4];
    int          send_idle;
    int          recv_idle;
    int          hold_cycles;
    int          items_sent;

    pqlru_req_if req ();
    pqlru_rsp_if rsp ();

    priority_queues_with_lru_eviction_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    priority_queues_with_lru_eviction_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .req           (req),
        .rsp           (rsp),
        .i_cfg_we      (psel && penable && pwrite && pready && paddr == REG_MAX_CACHE),
        .i_cfg_max     (pwdata[6:0]),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_kind_seen   (kind_seen)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAIL priority_queues_with_lru_eviction_top");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) rsp.ready <= 0;
        else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready <= 0;
        end else rsp.ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic write_limit(input int value);
        @(posedge i_clk);
        psel <= 1;
        pwrite <= 1;
        paddr <= REG_MAX_CACHE;
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic drain();
        while (outstanding != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic send_op(input logic [2:0] op, input int s, input int pr, input logic hi);
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle) @(posedge i_clk);
        req.valid <= 1;
        req.operation <= op;
        req.record <= 6'(s);
        req.priority_req <= 2'(pr);
        req.high_only <= hi;
        do @(posedge i_clk); while (!req.ready);
        req.valid <= 0;
        items_sent++;
    endtask

    task automatic send_random(input int count);
        int r;
        int op;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 25) op = OP_INSERT;
            else if (r < 45) op = OP_ADD_EVICT;
            else if (r < 55) op = OP_TOUCH;
            else if (r < 63) op = OP_REMOVE;
            else if (r < 72) op = OP_REPRIO;
            else if (r < 92) op = OP_DEQUEUE;
            else if (r < 97) op = OP_FLUSH;
            else op = 7;
            send_op(3'(op), ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(11),
                    $urandom_range(3), $urandom_range(1));
        end
    endtask

    initial begin
        i_rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        req.valid = 0;
        req.operation = '0;
        req.record = '0;
        req.priority_req = '0;
        req.high_only = 0;
        send_idle = 0;
        recv_idle = 0;
        hold_cycles = 0;
        items_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        send_op(OP_DEQUEUE, 0, 0, 0);
        send_op(OP_FLUSH, 0, 0, 0);
        send_op(OP_INSERT, 0, 0, 0);
        send_op(OP_INSERT, 63, 1, 0);
        send_op(OP_INSERT, 5, 2, 0);
        send_op(OP_INSERT, 6, 3, 0);
        send_op(OP_INSERT, 0, 1, 0);
        send_op(OP_REPRIO, 6, 0, 0);
        send_op(OP_REPRIO, 9, 1, 0);
        send_op(OP_DEQUEUE, 0, 0, 1);
        send_op(OP_DEQUEUE, 0, 0, 1);
        send_op(OP_DEQUEUE, 0, 0, 1);
        send_op(OP_ADD_EVICT, 63, 0, 0);
        send_op(OP_ADD_EVICT, 7, 0, 0);
        send_op(OP_ADD_EVICT, 63, 0, 0);
        send_op(OP_TOUCH, 7, 0, 0);
        send_op(OP_TOUCH, 20, 0, 0);
        send_op(OP_REMOVE, 5, 0, 0);
        send_op(OP_REMOVE, 21, 0, 0);
        send_op(OP_REMOVE, 7, 0, 0);
        send_op(3'd7, 42, 3, 1);
        send_op(OP_DEQUEUE, 0, 0, 0);
        send_op(OP_FLUSH, 0, 0, 0);
        drain();

        write_limit(0);
        send_op(OP_ADD_EVICT, 3, 0, 0);
        send_op(OP_ADD_EVICT, 4, 0, 0);
        drain();
        write_limit(2);
        send_idle = 9;
        recv_idle = 68;
        send_random(20);
        drain();

        write_limit(64);
        for (int i = 0; i < 64; i++) send_op(OP_ADD_EVICT, i, 0, 0);
        send_op(OP_ADD_EVICT, 10, 0, 0);
        send_op(OP_FLUSH, 0, 0, 0);
        drain();

        write_limit(4);
        send_idle = 68;
        recv_idle = 9;
        send_random(20);
        drain();

        write_limit(127);
        send_idle = 0;
        recv_idle = 0;
        hold_cycles = 300;
        send_random(20);
        drain();

        $display("Run covered %0d request transactions: %0d acks, %0d dequeues, %0d evictions,",
                 items_sent, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("%0d flushed entries, with eviction limits 0, 2, 4, 64 and 127.", kind_seen[3]);
        if (errors == 0) $display("PASS priority_queues_with_lru_eviction_top");
        else $display("FAIL priority_queues_with_lru_eviction_top");
        $finish;
    end

endmodule
